@@ hw/rtl/packet_frame_decoder_assert.svh @@
// Assertion macros used by the checker file.
`ifndef PACKET_FRAME_DECODER_ASSERT_SVH
`define PACKET_FRAME_DECODER_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, idle in reset.
`define PFD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("pfd check failed");

// Next-cycle implication, sampled on the rising clock, idle in reset.
`define PFD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("pfd check failed");

`endif

@@ hw/rtl/pfd_pkg.sv @@
package pfd_pkg;

    // Largest frame accepted as well formed, in bytes
    localparam logic [16:0] MAX_FRAME_BYTES = 17'd65535;

    // Result kinds
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    // Status codes, highest priority first after ok
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_TOO_SHORT = 3'd1;
    localparam logic [2:0] ST_BAD_ID    = 3'd2;
    localparam logic [2:0] ST_LEN_ERR   = 3'd3;
    localparam logic [2:0] ST_SUM_ERR   = 3'd4;

    // Byte positions in the frame
    localparam logic [15:0] POS_ID_HI   = 16'd0;
    localparam logic [15:0] POS_ID_LO   = 16'd1;
    localparam logic [15:0] POS_HDR_LO  = 16'd2;
    localparam logic [15:0] POS_HDR_HI  = 16'd5;
    localparam logic [15:0] POS_LEN_HI  = 16'd6;
    localparam logic [15:0] POS_LEN_LO  = 16'd7;
    localparam logic [15:0] POS_PAYLOAD = 16'd8;
    localparam logic [15:0] POS_SAT     = 16'hFFFF;
    localparam logic [16:0] MIN_FRAME   = 17'd11;
    localparam logic [16:0] FRAME_OVHD  = 17'd10;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last_byte;
    } t_in;

    typedef struct packed {
        logic        kind;
        logic [7:0]  payload_byte;
        logic [15:0] payload_index;
        logic [2:0]  status;
        logic [2:0]  version;
        logic        packet_type;
        logic        secondary_header;
        logic [10:0] apid;
        logic [1:0]  grouping;
        logic [13:0] sequence_count;
        logic [15:0] length_field;
        logic [15:0] checksum_received;
    } t_out;

endpackage

@@ hw/rtl/pfd_parser.sv @@
module pfd_parser
    import pfd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    input  logic        i_acc,
    input  t_in         i_in,
    output logic        o_res_valid,
    output t_out        o_res
);

    logic [15:0] r_frame_id;
    logic [15:0] r_pos,      n_pos;
    logic [7:0]  r_id_high,  n_id_high;
    logic        r_id_match, n_id_match;
    logic [31:0] r_hdr,      n_hdr;
    logic [15:0] r_len,      n_len;
    logic [15:0] r_sum,      n_sum;
    logic [7:0]  r_ck_high,  n_ck_high;

    logic        payload;
    logic [15:0] pay_idx;
    logic [16:0] count;
    logic [16:0] expected;
    logic [15:0] received;
    logic [2:0]  status;

    assign pay_idx  = r_pos - POS_PAYLOAD;
    assign payload  = (r_pos >= POS_PAYLOAD) && (r_pos != POS_SAT) && (pay_idx <= r_len);
    assign count    = {1'b0, r_pos} + 17'd1;
    assign expected = FRAME_OVHD + {1'b0, r_len + 16'd1};
    assign received = {r_ck_high, i_in.frame_byte};

    always_comb begin
        if (count < MIN_FRAME) begin
            status = ST_TOO_SHORT;
        end else if (!r_id_match) begin
            status = ST_BAD_ID;
        end else if (count > MAX_FRAME_BYTES || count != expected) begin
            status = ST_LEN_ERR;
        end else if (received != r_sum) begin
            status = ST_SUM_ERR;
        end else begin
            status = ST_OK;
        end
    end

    always_comb begin
        n_pos      = r_pos;
        n_id_high  = r_id_high;
        n_id_match = r_id_match;
        n_hdr      = r_hdr;
        n_len      = r_len;
        n_sum      = r_sum;
        n_ck_high  = r_ck_high;
        if (i_acc && !i_in.last_byte) begin
            if (r_pos == POS_ID_HI) begin
                n_id_high = i_in.frame_byte;
            end else if (r_pos == POS_ID_LO) begin
                n_id_match = ({r_id_high, i_in.frame_byte} == r_frame_id);
            end else if (r_pos >= POS_HDR_LO && r_pos <= POS_HDR_HI) begin
                n_hdr = {r_hdr[23:0], i_in.frame_byte};
            end else if (r_pos == POS_LEN_HI || r_pos == POS_LEN_LO) begin
                n_len = {r_len[7:0], i_in.frame_byte};
            end
            if (r_pos < POS_PAYLOAD || payload) begin
                n_sum = r_sum + {8'd0, i_in.frame_byte};
            end
            n_ck_high = i_in.frame_byte;
            if (r_pos != POS_SAT) begin
                n_pos = r_pos + 16'd1;
            end
        end else if (i_acc) begin
            // final byte: back to the start-of-frame state
            n_pos      = '0;
            n_id_high  = '0;
            n_id_match = 1'b0;
            n_hdr      = '0;
            n_len      = '0;
            n_sum      = '0;
            n_ck_high  = '0;
        end
    end

    always_comb begin
        o_res       = '0;
        o_res_valid = i_acc && (i_in.last_byte || payload);
        if (i_in.last_byte) begin
            o_res.kind   = KIND_STATUS;
            o_res.status = status;
            if (status == ST_OK || status == ST_LEN_ERR || status == ST_SUM_ERR) begin
                o_res.version          = r_hdr[31:29];
                o_res.packet_type      = r_hdr[28];
                o_res.secondary_header = r_hdr[27];
                o_res.apid             = r_hdr[26:16];
                o_res.grouping         = r_hdr[15:14];
                o_res.sequence_count   = r_hdr[13:0];
                o_res.length_field     = r_len;
            end
            if (status == ST_OK || status == ST_SUM_ERR) begin
                o_res.checksum_received = received;
            end
        end else begin
            o_res.kind          = KIND_PAYLOAD;
            o_res.payload_byte  = i_in.frame_byte;
            o_res.payload_index = pay_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_id <= '0;
            r_pos      <= '0;
            r_id_high  <= '0;
            r_id_match <= 1'b0;
            r_hdr      <= '0;
            r_len      <= '0;
            r_sum      <= '0;
            r_ck_high  <= '0;
        end else begin
            if (i_cfg_we) begin
                r_frame_id <= i_cfg_data;
            end
            r_pos      <= n_pos;
            r_id_high  <= n_id_high;
            r_id_match <= n_id_match;
            r_hdr      <= n_hdr;
            r_len      <= n_len;
            r_sum      <= n_sum;
            r_ck_high  <= n_ck_high;
        end
    end

endmodule

@@ hw/rtl/pfd_out_buf.sv @@
module pfd_out_buf
    import pfd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_out i_data,
    output logic o_full,
    output logic o_valid,
    input  logic i_stall,
    output t_out o_data
);

    // two-entry result queue: head drives the port, tail catches a stalled push
    logic [1:0] r_count, n_count;
    t_out       r_head,  n_head;
    t_out       r_tail,  n_tail;
    logic       pop;

    assign pop     = (r_count != 2'd0) && !i_stall;
    assign o_valid = (r_count != 2'd0);
    assign o_full  = (r_count == 2'd2);
    assign o_data  = r_head;

    always_comb begin
        n_count = r_count;
        n_head  = r_head;
        n_tail  = r_tail;
        case ({i_push, pop})
            2'b01: begin
                n_head  = r_tail;
                n_count = r_count - 2'd1;
            end
            2'b10: begin
                if (r_count == 2'd0) begin
                    n_head = i_data;
                end else begin
                    n_tail = i_data;
                end
                n_count = r_count + 2'd1;
            end
            2'b11: begin
                // push is never taken while full, so one entry is held here
                n_head = i_data;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
        r_head <= n_head;
        r_tail <= n_tail;
    end

endmodule

@@ hw/rtl/packet_frame_decoder.sv @@
// Results of taken requests are registered in the output queue that drives o_out_data.
// Throughput: one byte per cycle unless stalled; each: counter step, compare and add.
// Input stalls only while both result slots of the output queue are occupied.
// Reset: synchronous, active low; clears frame state, frame_id and the output queue.
module packet_frame_decoder
    import pfd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in         i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out        o_out_data
);

    // request taken when valid and the queue has room
    logic in_acc;
    logic res_valid;
    t_out res;
    logic full;

    assign in_acc     = i_in_valid && !full;
    assign o_in_stall = full;

    // Frame parser: position counter, ID/header/length capture, running sum,
    // and the payload or status result formed in the same cycle.
    pfd_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_acc       (in_acc),
        .i_in        (i_in_data),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // Result registers: two slots, so a waiting result does not hold up input.
    pfd_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_data  (res),
        .o_full  (full),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (o_out_data)
    );

endmodule

@@ hw/rtl/pfd_checker.sv @@
`include "packet_frame_decoder_assert.svh"

module pfd_checker
    import pfd_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic o_in_stall,
    input logic o_out_valid,
    input logic i_out_stall,
    input t_out o_out_data
);

    logic out_payload;
    logic payload_clean;
    logic out_early_err;
    logic early_clean;

    assign out_payload   = o_out_valid && (o_out_data.kind == KIND_PAYLOAD);
    assign payload_clean = (o_out_data.status == ST_OK) &&
                           (o_out_data.length_field == 16'd0) &&
                           (o_out_data.checksum_received == 16'd0);
    assign out_early_err = o_out_valid && (o_out_data.kind == KIND_STATUS) &&
                           (o_out_data.status == ST_TOO_SHORT ||
                            o_out_data.status == ST_BAD_ID);
    assign early_clean   = (o_out_data.apid == 11'd0) &&
                           (o_out_data.length_field == 16'd0) &&
                           (o_out_data.checksum_received == 16'd0);

    // stalled result holds
    `PFD_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data))

    // input only stalls with results pending
    `PFD_ASSERT_NOW(a_stall_pending, o_in_stall, o_out_valid)

    // payload results carry status ST_OK and no length field or checksum
    `PFD_ASSERT_NOW(a_payload_clean, out_payload, payload_clean)

    // early errors report no APID, length field or checksum
    `PFD_ASSERT_NOW(a_early_err, out_early_err, early_clean)

endmodule

bind packet_frame_decoder pfd_checker u_pfd_checker (.*);

@@ dv/tb_packet_frame_decoder.sv @@
`timescale 1ns / 100ps

module tb_packet_frame_decoder;
    import pfd_pkg::*;

    localparam int CLK_HALF     = 4;
    localparam int RESET_CYCLES = 11;
    // Longest run of cycles with no transfer on either side before giving up.
    // The deliberate receiver hold-off is well inside this.
    localparam int QUIET_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 300;
    // Spare cycles waited after the last owed result so the pipeline settles.
    localparam int DRAIN_CYCLES = 4;
    localparam int RANDOM_BYTES = 1000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [15:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_stall;
    t_in         i_in_data;
    logic        o_out_valid;
    logic        i_out_stall;
    t_out        o_out_data;

    packet_frame_decoder dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // Shadow of the decoder: configured sync ID plus the per-frame parse state.
    logic [15:0] frame_id_reg;
    logic [15:0] frame_pos;     // saturating byte position
    logic [7:0]  id_hi_byte;
    logic        id_ok;
    logic [31:0] hdr_word;      // header bytes 2..5
    logic [15:0] len_word;      // header length field
    logic [15:0] sum16;         // wrapping sum of ID, header and payload bytes
    logic [7:0]  prev_byte;     // candidate checksum high byte

    t_out        decoded_q[$];  // decoded results still owed by the block
    logic [7:0]  frame_bytes[$];
    t_out        want;
    int          error_count = 0;
    int          quiet_cycles = 0;
    int          bytes_sent = 0;
    int          hold_len = 0;
    bit          idle_on = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    function automatic void clear_frame_state();
        frame_pos  = '0;
        id_hi_byte = '0;
        id_ok      = 1'b0;
        hdr_word   = '0;
        len_word   = '0;
        sum16      = '0;
        prev_byte  = '0;
    endfunction

    // Work out what one accepted byte request produces; queue it if anything.
    function automatic void decode_byte(input logic [7:0] b, input logic last);
        t_out        r;
        logic        in_payload;
        logic [16:0] count;
        logic [16:0] expected_cnt;
        logic [15:0] rx_sum;
        logic [2:0]  st;
        r = '0;
        if (!last) begin
            // Saturated position never counts as payload
            in_payload = frame_pos >= POS_PAYLOAD && frame_pos != POS_SAT &&
                         (frame_pos - POS_PAYLOAD) <= len_word;
            if (frame_pos == POS_ID_HI) begin
                id_hi_byte = b;
            end else if (frame_pos == POS_ID_LO) begin
                id_ok = ({id_hi_byte, b} == frame_id_reg);
            end else if (frame_pos >= POS_HDR_LO && frame_pos <= POS_HDR_HI) begin
                hdr_word = {hdr_word[23:0], b};
            end else if (frame_pos == POS_LEN_HI || frame_pos == POS_LEN_LO) begin
                len_word = {len_word[7:0], b};
            end
            if (frame_pos < POS_PAYLOAD || in_payload)
                sum16 = sum16 + {8'd0, b};
            prev_byte = b;
            if (in_payload) begin
                r.kind          = KIND_PAYLOAD;
                r.payload_byte  = b;
                r.payload_index = frame_pos - POS_PAYLOAD;
                decoded_q.push_back(r);
            end
            if (frame_pos != POS_SAT)
                frame_pos = frame_pos + 16'd1;
        end else begin
            count        = {1'b0, frame_pos} + 17'd1;
            // Length field + 1 wraps at 16 bits before the overhead is added
            expected_cnt = FRAME_OVHD + {1'b0, len_word + 16'd1};
            rx_sum       = {prev_byte, b};
            if (count < MIN_FRAME)
                st = ST_TOO_SHORT;
            else if (!id_ok)
                st = ST_BAD_ID;
            else if (count > MAX_FRAME_BYTES || count != expected_cnt)
                st = ST_LEN_ERR;
            else if (rx_sum != sum16)
                st = ST_SUM_ERR;
            else
                st = ST_OK;
            r.kind   = KIND_STATUS;
            r.status = st;
            if (st == ST_OK || st == ST_LEN_ERR || st == ST_SUM_ERR) begin
                r.version          = hdr_word[31:29];
                r.packet_type      = hdr_word[28];
                r.secondary_header = hdr_word[27];
                r.apid             = hdr_word[26:16];
                r.grouping         = hdr_word[15:14];
                r.sequence_count   = hdr_word[13:0];
                r.length_field     = len_word;
            end
            if (st == ST_OK || st == ST_SUM_ERR)
                r.checksum_received = rx_sum;
            decoded_q.push_back(r);
            clear_frame_state();
        end
    endfunction

    task automatic report_error(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        error_count++;
    endtask

    // Result checker: every accepted result against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (decoded_q.size() == 0) begin
                report_error("result with nothing outstanding");
            end else begin
                want = decoded_q.pop_front();
                if (o_out_data !== want)
                    report_error($sformatf("result %h want %h", o_out_data, want));
            end
        end
    end

    // Watchdog: any request or result moving resets the count.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: %0d cycles without a transfer", QUIET_LIMIT);
            $display("FAILURE");
            $finish;
        end
    end

    // Receiver side: random stall bursts, plus one long hold-off on demand.
    initial begin
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_len != 0) begin
                i_out_stall <= 1'b1;
                repeat (hold_len) @(posedge i_clk);
                hold_len = 0;
                i_out_stall <= 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 13)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    // One byte request. Valid is left high on return so back-to-back requests
    // never lower and raise it in the same step.
    task automatic send_byte(input logic [7:0] b, input logic last);
        t_in item;
        item.frame_byte = b;
        item.last_byte  = last;
        if (idle_on && $urandom_range(0, 7) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do @(posedge i_clk); while (o_in_stall);
        decode_byte(b, last);
        bytes_sent++;
    endtask

    task automatic send_frame();
        int k;
        for (k = 0; k < frame_bytes.size(); k++)
            send_byte(frame_bytes[k], k == frame_bytes.size() - 1);
    endtask

    // Sync ID, header, length field, payload, then the big-endian sum of all
    // of those (optionally corrupted by sum_flip). fill < 0 means random payload.
    task automatic build_frame(input logic [15:0] id, input logic [31:0] hdr,
                               input logic [15:0] len_field, input int plen,
                               input int fill, input logic [15:0] sum_flip);
        logic [15:0] s;
        int          k;
        frame_bytes.delete();
        frame_bytes.push_back(id[15:8]);
        frame_bytes.push_back(id[7:0]);
        frame_bytes.push_back(hdr[31:24]);
        frame_bytes.push_back(hdr[23:16]);
        frame_bytes.push_back(hdr[15:8]);
        frame_bytes.push_back(hdr[7:0]);
        frame_bytes.push_back(len_field[15:8]);
        frame_bytes.push_back(len_field[7:0]);
        for (k = 0; k < plen; k++)
            frame_bytes.push_back(fill < 0 ? 8'($urandom) : 8'(fill));
        s = '0;
        for (k = 0; k < frame_bytes.size(); k++)
            s = s + {8'd0, frame_bytes[k]};
        s = s ^ sum_flip;
        frame_bytes.push_back(s[15:8]);
        frame_bytes.push_back(s[7:0]);
    endtask

    task automatic build_noise(input int n);
        frame_bytes.delete();
        repeat (n) frame_bytes.push_back(8'($urandom));
    endtask

    // Lower valid, let every owed result come back and the pipe settle.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (decoded_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_frame_id(input logic [15:0] v);
        wait_drained();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        frame_id_reg = v;
    endtask

    // Mostly well-formed frames with random content; the rest are broken in
    // one way each, short, or plain noise.
    task automatic send_random_frame();
        int          pick;
        int          plen;
        logic [15:0] id;
        logic [15:0] lf;
        logic [15:0] flip;
        pick = $urandom_range(0, 99);
        plen = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 300) : $urandom_range(1, 24);
        id   = frame_id_reg;
        lf   = 16'(plen - 1);
        flip = '0;
        if (pick >= 93) begin
            build_noise($urandom_range(1, 40));
        end else if (pick >= 85) begin
            build_noise($urandom_range(1, 10));
        end else begin
            if (pick >= 78)
                id = id ^ (16'd1 << $urandom_range(0, 15));
            else if (pick >= 70)
                lf = $urandom_range(0, 1) ? lf + 16'($urandom_range(1, 3)) : 16'($urandom);
            else if (pick >= 60)
                flip = 16'($urandom_range(1, 16'hFFFF));
            build_frame(id, $urandom, lf, plen, -1, flip);
        end
        send_frame();
    endtask

    // Minimum-size frame at the reset ID of zero, then all-ones ID, header and payload.
    task automatic test_good_frames();
        build_frame(16'h0000, 32'h0000_0000, 16'd0, 1, 8'h00, 16'h0000);
        send_frame();
        write_frame_id(16'hFFFF);
        build_frame(16'hFFFF, 32'hFFFF_FFFF, 16'd1, 2, 8'hFF, 16'h0000);
        send_frame();
    endtask

    // Single-byte frame and one byte short of the minimum.
    task automatic test_short_frames();
        build_noise(1);
        send_frame();
        build_noise(10);
        send_frame();
    endtask

    task automatic test_bad_id();
        build_frame(16'hFFFE, $urandom, 16'd0, 1, -1, 16'h0000);
        send_frame();
    endtask

    // Length field claiming more bytes than sent, then fewer.
    task automatic test_length_mismatch();
        build_frame(frame_id_reg, $urandom, 16'd3, 2, -1, 16'h0000);
        send_frame();
        build_frame(frame_id_reg, $urandom, 16'd0, 2, -1, 16'h0000);
        send_frame();
    endtask

    task automatic test_checksum_error();
        build_frame(frame_id_reg, $urandom, 16'd0, 1, -1, 16'h8001);
        send_frame();
    endtask

    // Receiver holds off while the sender keeps offering requests, so the
    // output queue fills and input stall must be raised.
    task automatic test_backpressure();
        idle_on  = 1'b0;
        hold_len = HOLD_CYCLES;
        repeat (8) begin
            build_frame(frame_id_reg, $urandom, 16'd11, 12, -1, 16'h0000);
            send_frame();
        end
        wait_drained();
        idle_on = 1'b1;
    endtask

    // Random traffic across several sync ID settings, extremes included.
    task automatic test_random_traffic();
        logic [15:0] ids[4];
        int          start;
        ids[0] = 16'($urandom);
        ids[1] = 16'hFFFF;
        ids[2] = 16'h0000;
        ids[3] = 16'($urandom);
        foreach (ids[p]) begin
            write_frame_id(ids[p]);
            start = bytes_sent;
            while (bytes_sent - start < RANDOM_BYTES / 4)
                send_random_frame();
        end
    endtask

    // A long well-formed frame, then a few random frames back to back.
    // No idling from here on.
    task automatic test_long_frames();
        idle_on = 1'b0;
        build_frame(frame_id_reg, $urandom, 16'd99, 100, -1, 16'h0000);
        send_frame();
        repeat (6) send_random_frame();
    endtask

    initial begin
        i_rst_n    <= 1'b0;
        i_cfg_we   <= 1'b0;
        i_cfg_data <= '0;
        i_in_valid <= 1'b0;
        i_in_data  <= '0;
        frame_id_reg = '0;
        clear_frame_state();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        idle_on = 1'b1;

        test_good_frames();
        test_short_frames();
        test_bad_id();
        test_length_mismatch();
        test_checksum_error();
        test_backpressure();
        test_random_traffic();
        test_long_frames();

        wait_drained();
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
